/* hdl/ght_pkg.sv */
// ght_pkg: shared constants, codes and types of the glyph hash table
// depends on nothing; used by every module in hdl
`timescale 1ns / 1ps
`default_nettype none
package ght_pkg;
   localparam int SLOTS   = 1024;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int CNT_W   = IDX_W + 1;
   localparam int KEY_W   = 16;
   localparam int PAY_W   = 32;
   localparam int SIZE_W  = 11;
   localparam int LIMIT_W = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int DIV_STEPS = KEY_W / 2;
   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam int DIV3_MUL = 2731;
   localparam int DIV3_SHIFT = 13;

   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 11'd1024;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd815;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_ADD    = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [KEY_W-1:0]    key;
      logic [PAY_W-1:0]    payload;
      logic [IDX_W-1:0]    home;
      logic [SIZE_W-1:0]   size;
      logic [SIZE_W-1:0]   skip;
   } qentry_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_SWEEP,
      B_IDLE,
      B_READ,
      B_CHECK
   } back_state_type;
endpackage
`default_nettype wire

/* hdl/glyph_hash_table_core.sv */
// glyph_hash_table_core: top level, config registers, front, queue, back
// depends on ght_pkg, ght_front, ght_queue, ght_back
//
//   channel   ports   dir  contents
//   request   req_*   in   operation, key, payload
//   response  rsp_*   out  found, payload_out, status, replaced
//   config    csr_*   in   index, wdata (table_size, glyph_limit)
//
// front: accept (F_IDLE), key mod size (F_DIV), push to the queue when it is not full (F_PUSH)
// back: each probed slot is read (B_READ), then checked (B_CHECK), in the slot memories
// reset and clear each run a sweep of all 1024 slots of the key memory
// a waiting response blocks only the back; the front keeps taking requests until the queue is full
`timescale 1ns / 1ps
`default_nettype none
module glyph_hash_table_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_operation,
   input  wire logic [ght_pkg::KEY_W-1:0]        req_key,
   input  wire logic [ght_pkg::PAY_W-1:0]        req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_found,
   output logic [ght_pkg::PAY_W-1:0]             rsp_payload_out,
   output logic                                  rsp_status,
   output logic                                  rsp_replaced,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ght_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ght_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   logic [ght_pkg::SIZE_W-1:0]  table_size_ff;
   logic [ght_pkg::LIMIT_W-1:0] glyph_limit_ff;
   logic                        q_push, q_pop, q_full, q_empty;
   ght_pkg::qentry_type         q_in, q_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= ght_pkg::SIZE_RESET;
         glyph_limit_ff <= ght_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ght_pkg::CSR_TABLE_SIZE:  table_size_ff <= csr_wdata[ght_pkg::SIZE_W-1:0];
            ght_pkg::CSR_GLYPH_LIMIT: glyph_limit_ff <= csr_wdata[ght_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ght_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_key       (req_key),
      .req_payload   (req_payload),
      .table_size    (table_size_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_in)
   );

   ght_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   ght_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_out),
      .q_pop           (q_pop),
      .glyph_limit     (glyph_limit_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_payload_out (rsp_payload_out),
      .rsp_status      (rsp_status),
      .rsp_replaced    (rsp_replaced)
   );
endmodule
`default_nettype wire

/* hdl/ght_front.sv */
// ght_front: takes requests, clamps size, works out skip and home slot
// home = key mod size, two key bits a cycle; uses ght_pkg
`timescale 1ns / 1ps
`default_nettype none
module ght_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_operation,
   input  wire logic [ght_pkg::KEY_W-1:0]     req_key,
   input  wire logic [ght_pkg::PAY_W-1:0]     req_payload,
   input  wire logic [ght_pkg::SIZE_W-1:0]    table_size,
   input  wire logic                          q_full,
   output logic                               q_push,
   output ght_pkg::qentry_type                q_data
);
   ght_pkg::front_state_type state_ff, state_in;
   logic [1:0]                      op_ff;
   logic [ght_pkg::KEY_W-1:0]       key_ff, shreg_ff, shreg_in;
   logic [ght_pkg::PAY_W-1:0]       pay_ff;
   logic [ght_pkg::SIZE_W-1:0]      size_ff, skip_ff, sz, skip;
   logic [ght_pkg::IDX_W-1:0]       rem_ff, rem_in, rem_mid;
   logic [ght_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [23:0]                     prod;
   logic [ght_pkg::SIZE_W-1:0]      t0, t1;
   logic                            accept;

   always_comb begin
      if (table_size == '0) begin
         sz = ght_pkg::SIZE_W'(1);
      end else if (table_size > ght_pkg::SIZE_W'(ght_pkg::SLOTS)) begin
         sz = ght_pkg::SIZE_W'(ght_pkg::SLOTS);
      end else begin
         sz = table_size;
      end
   end

   assign prod = 24'({sz, 1'b0}) * 24'(ght_pkg::DIV3_MUL);
   assign skip = ght_pkg::SIZE_W'(prod >> ght_pkg::DIV3_SHIFT) | ght_pkg::SIZE_W'(1);

   // restoring remainder, two key bits a cycle
   always_comb begin
      t0 = {rem_ff, shreg_ff[ght_pkg::KEY_W-1]};
      rem_mid = (t0 >= size_ff) ? ght_pkg::IDX_W'(t0 - size_ff) : t0[ght_pkg::IDX_W-1:0];
      t1 = {rem_mid, shreg_ff[ght_pkg::KEY_W-2]};
      rem_in = (t1 >= size_ff) ? ght_pkg::IDX_W'(t1 - size_ff) : t1[ght_pkg::IDX_W-1:0];
      shreg_in = {shreg_ff[ght_pkg::KEY_W-3:0], 2'b00};
      step_in = step_ff + ght_pkg::STEP_W'(1);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ght_pkg::F_IDLE: begin
            if (req_valid) state_in = ght_pkg::F_DIV;
         end
         ght_pkg::F_DIV: begin
            if (step_ff == ght_pkg::STEP_W'(ght_pkg::DIV_STEPS - 1)) state_in = ght_pkg::F_PUSH;
         end
         ght_pkg::F_PUSH: begin
            if (!q_full) state_in = ght_pkg::F_IDLE;
         end
         default: state_in = ght_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ght_pkg::F_IDLE);
      q_push = (state_ff == ght_pkg::F_PUSH) && !q_full;
      accept = req_valid && req_ready;
      q_data.op = ght_pkg::op_type'(op_ff);
      q_data.key = key_ff;
      q_data.payload = pay_ff;
      q_data.home = rem_ff;
      q_data.size = size_ff;
      q_data.skip = skip_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ght_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_operation;
         key_ff <= req_key;
         pay_ff <= req_payload;
         shreg_ff <= req_key;
         size_ff <= sz;
         skip_ff <= skip;
         rem_ff <= '0;
         step_ff <= '0;
      end else if (state_ff == ght_pkg::F_DIV) begin
         shreg_ff <= shreg_in;
         rem_ff <= rem_in;
         step_ff <= step_in;
      end
   end
endmodule
`default_nettype wire

/* hdl/ght_queue.sv */
// ght_queue: short queue of classified requests between front and back
// holds ght_pkg::qentry_type items
`timescale 1ns / 1ps
`default_nettype none
module ght_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire ght_pkg::qentry_type  push_data,
   input  wire logic                 pop,
   output ght_pkg::qentry_type       pop_data,
   output logic                      full,
   output logic                      empty
);
   ght_pkg::qentry_type entry_ff [ght_pkg::QUEUE_DEPTH];
   logic [ght_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [ght_pkg::QPTR_W:0]   count_ff, count_in;

   always_comb begin
      full = (count_ff == (ght_pkg::QPTR_W+1)'(ght_pkg::QUEUE_DEPTH));
      empty = (count_ff == '0);
      pop_data = entry_ff[rd_ff];
      wr_in = push ? wr_ff + ght_pkg::QPTR_W'(1) : wr_ff;
      rd_in = pop ? rd_ff + ght_pkg::QPTR_W'(1) : rd_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + (ght_pkg::QPTR_W+1)'(1);
      if (pop && !push) count_in = count_ff - (ght_pkg::QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

/* hdl/ght_back.sv */
// ght_back: probe engine over the slot memories, result register
// uses ght_pkg; slot memories live here, and the key memory is swept on reset and clear
`timescale 1ns / 1ps
`default_nettype none
module ght_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_empty,
   input  wire ght_pkg::qentry_type          q_data,
   output logic                              q_pop,
   input  wire logic [ght_pkg::LIMIT_W-1:0]  glyph_limit,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_found,
   output logic [ght_pkg::PAY_W-1:0]         rsp_payload_out,
   output logic                              rsp_status,
   output logic                              rsp_replaced
);
   localparam int KW = ght_pkg::KEY_W + 1;

   logic [KW-1:0]              kmem [ght_pkg::SLOTS];
   logic [ght_pkg::PAY_W-1:0]  pmem [ght_pkg::SLOTS];

   ght_pkg::back_state_type    state_ff, state_in;
   ght_pkg::qentry_type        cur_ff, cur_in;
   logic [ght_pkg::IDX_W-1:0]  idx_ff, idx_in, sweep_ff, sweep_in;
   logic [ght_pkg::CNT_W-1:0]  cnt_ff, cnt_in, used_ff, used_in, cnt_nx;
   logic [KW-1:0]              kd_ff, kwd;
   logic [ght_pkg::PAY_W-1:0]  pd_ff, pwd;
   logic                       kwe, pwe;
   logic [ght_pkg::IDX_W-1:0]  kwa, pwa;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       found_ff, found_in, status_ff, status_in;
   logic                       repl_ff, repl_in;
   logic [ght_pkg::PAY_W-1:0]  pout_ff, pout_in;
   logic                       kvalid, kmatch, exhausted, resolve, take;
   logic [ght_pkg::SIZE_W-1:0] idx_ext, nxt_a;
   logic [ght_pkg::IDX_W-1:0]  nxt;

   always_comb begin
      kvalid = kd_ff[ght_pkg::KEY_W];
      kmatch = (kd_ff[ght_pkg::KEY_W-1:0] == cur_ff.key);
      idx_ext = {1'b0, idx_ff};
      if (idx_ext >= cur_ff.skip) begin
         nxt_a = idx_ext - cur_ff.skip;
      end else begin
         nxt_a = idx_ext + cur_ff.size - cur_ff.skip;
      end
      nxt = (nxt_a >= cur_ff.size) ? '0 : nxt_a[ght_pkg::IDX_W-1:0];
      cnt_nx = cnt_ff + ght_pkg::CNT_W'(1);
      exhausted = (cnt_nx == cur_ff.size);
      resolve = !kvalid || kmatch || exhausted;
      take = (state_ff == ght_pkg::B_IDLE) && !q_empty && !rsp_valid_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ght_pkg::B_SWEEP: begin
            if (sweep_ff == ght_pkg::IDX_W'(ght_pkg::SLOTS - 1)) state_in = ght_pkg::B_IDLE;
         end
         ght_pkg::B_IDLE: begin
            if (take) begin
               case (q_data.op)
                  ght_pkg::OP_LOOKUP: state_in = ght_pkg::B_READ;
                  ght_pkg::OP_ADD:    state_in = ght_pkg::B_READ;
                  ght_pkg::OP_CLEAR:  state_in = ght_pkg::B_SWEEP;
                  default:            state_in = ght_pkg::B_IDLE;
               endcase
            end
         end
         ght_pkg::B_READ: state_in = ght_pkg::B_CHECK;
         ght_pkg::B_CHECK: begin
            state_in = resolve ? ght_pkg::B_IDLE : ght_pkg::B_READ;
         end
         default: state_in = ght_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      q_pop = take;
      cur_in = cur_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      used_in = used_ff;
      sweep_in = sweep_ff;
      kwe = 1'b0;
      kwa = idx_ff;
      kwd = {1'b1, cur_ff.key};
      pwe = 1'b0;
      pwa = idx_ff;
      pwd = cur_ff.payload;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in = found_ff;
      status_in = status_ff;
      repl_in = repl_ff;
      pout_in = pout_ff;
      case (state_ff)
         ght_pkg::B_SWEEP: begin
            kwe = 1'b1;
            kwa = sweep_ff;
            kwd = '0;
            sweep_in = sweep_ff + ght_pkg::IDX_W'(1);
         end
         ght_pkg::B_IDLE: begin
            if (take) begin
               cur_in = q_data;
               idx_in = q_data.home;
               cnt_in = '0;
               if (q_data.op == ght_pkg::OP_CLEAR || q_data.op == ght_pkg::OP_NONE) begin
                  rsp_valid_in = 1'b1;
                  found_in = 1'b0;
                  status_in = 1'b0;
                  repl_in = 1'b0;
                  pout_in = '0;
               end
               if (q_data.op == ght_pkg::OP_CLEAR) begin
                  used_in = '0;
                  sweep_in = '0;
               end
            end
         end
         ght_pkg::B_CHECK: begin
            if (!resolve) begin
               idx_in = nxt;
               cnt_in = cnt_nx;
            end else begin
               rsp_valid_in = 1'b1;
               found_in = 1'b0;
               status_in = 1'b0;
               repl_in = 1'b0;
               pout_in = '0;
               if (cur_ff.op == ght_pkg::OP_LOOKUP) begin
                  if (kvalid && kmatch) begin
                     found_in = 1'b1;
                     pout_in = pd_ff;
                  end
               end else if (kvalid && kmatch) begin
                  pwe = 1'b1;
                  found_in = 1'b1;
                  repl_in = 1'b1;
               end else if (kvalid) begin
                  status_in = 1'b1;
               end else if (used_ff >= ght_pkg::CNT_W'(glyph_limit)) begin
                  status_in = 1'b1;
               end else begin
                  kwe = 1'b1;
                  pwe = 1'b1;
                  used_in = used_ff + ght_pkg::CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid = rsp_valid_ff;
      rsp_found = found_ff;
      rsp_payload_out = pout_ff;
      rsp_status = status_ff;
      rsp_replaced = repl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ght_pkg::B_SWEEP;
         sweep_ff <= '0;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      found_ff <= found_in;
      status_ff <= status_in;
      repl_ff <= repl_in;
      pout_ff <= pout_in;
   end

   always_ff @(posedge clock) begin
      if (kwe) kmem[kwa] <= kwd;
      kd_ff <= kmem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (pwe) pmem[pwa] <= pwd;
      pd_ff <= pmem[idx_ff];
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= ght_pkg::CNT_W'(ght_pkg::SLOTS))
      else $error("used count above slot count");
   a_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(status_ff && repl_ff))
      else $error("refused and replaced together");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ght_pkg::B_CHECK |-> {1'b0, idx_ff} < cur_ff.size)
      else $error("probe slot outside table");
   a_sweep_nopop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ght_pkg::B_SWEEP |=> !$past(q_pop))
      else $error("request taken during sweep");
endmodule
`default_nettype wire
